// File: hw/rtl/json_string_unescape_utf8_assert.svh
// Assertion macros shared by the checker files of the string unescaper.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// Implication checked in the same cycle, masked while reset is asserted.
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent; the antecedent carries any reset term itself.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/jsu_pkg.sv
// Shared types and constants of the string unescaper.
`default_nettype none

package jsu_pkg;

    typedef logic [7:0] char_t;

    localparam int MAX_RESULTS = 4;
    localparam int IDX_W       = $clog2(MAX_RESULTS);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam char_t CHAR_BSLASH = 8'h5C;
    localparam char_t CHAR_U      = 8'h75;
    localparam char_t CHAR_N      = 8'h6E;
    localparam char_t CHAR_R      = 8'h72;
    localparam char_t CHAR_T      = 8'h74;
    localparam char_t CHAR_LF     = 8'h0A;
    localparam char_t CHAR_CR     = 8'h0D;
    localparam char_t CHAR_TAB    = 8'h09;

    localparam logic [15:0] CP_TWO_BYTE   = 16'h0080;
    localparam logic [15:0] CP_THREE_BYTE = 16'h0800;
    localparam char_t       LEAD_TWO      = 8'hC0;
    localparam char_t       LEAD_THREE    = 8'hE0;
    localparam char_t       CONT_MARK     = 8'h80;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } mode_t;

    // One request's worth of result bytes, as queued between front and back.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] data;
        logic [CNT_W-1:0]            count;
        logic                        last;
    } jsu_entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/json_string_unescape_utf8.sv
// Top level of the streaming string unescaper with UTF-8 output.
//
// Source bytes of an escaped string arrive on the s_ channel, one byte per
// request, with s_tlast on the final byte of each string. Escapes \" \\ \n
// \r \t and \uXXXX are decoded; \u values come out as one to three UTF-8
// bytes. Results leave on the m_ channel one byte per request; bit 8 of
// m_tdata marks the last byte caused by a source byte and m_tlast the final
// byte of the whole string.
// A source byte is accepted in the cycle it is offered while the four-entry
// queue between decoder and output stage has room, so bytes that produce at
// most one result stream at one per cycle. A source byte producing several
// results occupies the output stage until each has been sent in turn; bytes
// producing none are discarded there. The first result of a byte passes
// through the queue and the output register before it is offered on m_.
// Reset clears the decode state, the queue and the output valid flag;
// s_tready is high once reset is released. When the receiver stalls, the
// output holds its byte, the queue fills, and s_tready drops once it is full.
`default_nettype none

module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
    output logic             m_tlast
);

    jsu_entry_t push_entry;
    jsu_entry_t head;
    logic       push;
    logic       pop;
    logic       empty;
    logic       full;

    jsu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    jsu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    jsu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: hw/rtl/jsu_queue.sv
// Short FIFO of decoded entries between the front and back parts.
`default_nettype none

module jsu_queue
    import jsu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire jsu_entry_t push_entry,
    input  wire logic       pop,
    output jsu_entry_t      head,
    output logic            empty,
    output logic            full
);

    jsu_entry_t             entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]      fill_reg, fill_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head  = entries_reg[rd_ptr_reg];
    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// File: hw/rtl/jsu_front.sv
// Front part: accepts source bytes, tracks escape state and decodes each request's result bytes.
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,
    input  wire logic       queue_full,
    output logic            push,
    output jsu_entry_t      push_entry
);

    mode_t          mode_reg, mode_next;
    logic [1:0]     count_reg, count_next;
    logic [15:0]    code_reg, code_next;
    logic           stopped_reg, stopped_next;
    char_t          held_reg [3];
    logic           held_we;

    char_t          c;
    logic           fin;
    logic           hex_ok;
    logic [3:0]     hex_val;
    logic [15:0]    code_take;
    logic           stop_take;

    function automatic jsu_entry_t push_char(input jsu_entry_t r, input char_t b);
        jsu_entry_t o;
        o = r;
        if (o.count < CNT_W'(MAX_RESULTS)) begin
            o.data[o.count[IDX_W-1:0]] = b;
            o.count = o.count + 1'b1;
        end
        return o;
    endfunction

    function automatic char_t escape_map(input char_t ch);
        char_t o;
        case (ch)
            CHAR_N:  o = CHAR_LF;
            CHAR_R:  o = CHAR_CR;
            CHAR_T:  o = CHAR_TAB;
            default: o = ch;
        endcase
        return o;
    endfunction

    function automatic jsu_entry_t utf8_encode(input logic [15:0] cp);
        jsu_entry_t r;
        r = '0;
        if (cp < CP_TWO_BYTE) begin
            r = push_char(r, cp[7:0]);
        end else if (cp < CP_THREE_BYTE) begin
            r = push_char(r, LEAD_TWO | {3'b000, cp[10:6]});
            r = push_char(r, CONT_MARK | {2'b00, cp[5:0]});
        end else begin
            r = push_char(r, LEAD_THREE | {4'b0000, cp[15:12]});
            r = push_char(r, CONT_MARK | {2'b00, cp[11:6]});
            r = push_char(r, CONT_MARK | {2'b00, cp[5:0]});
        end
        return r;
    endfunction

    // The string ended inside a \u: emit 'u', then run the held characters and
    // the final byte through the ordinary rules. A nested \u can only be met
    // with the final byte next, which then comes out as 'u' and itself.
    function automatic jsu_entry_t replay_held(input char_t h0, input char_t h1,
                                               input logic [1:0] n, input char_t ch_last);
        jsu_entry_t r;
        mode_t      m;
        char_t      ch;
        logic       f;
        r = '0;
        r = push_char(r, CHAR_U);
        m = MODE_NORMAL;
        for (int k = 0; k < 3; k++) begin
            if (2'(k) <= n) begin
                f  = (2'(k) == n);
                ch = f ? ch_last : ((k == 0) ? h0 : h1);
                case (m)
                    MODE_ESCAPE: begin
                        m = MODE_NORMAL;
                        if (ch == CHAR_U) begin
                            if (f) begin
                                r = push_char(r, CHAR_U);
                            end else begin
                                m = MODE_HEX;
                            end
                        end else begin
                            r = push_char(r, escape_map(ch));
                        end
                    end
                    MODE_HEX: begin
                        r = push_char(r, CHAR_U);
                        r = push_char(r, ch);
                    end
                    default: begin
                        if (ch == CHAR_BSLASH && !f) begin
                            m = MODE_ESCAPE;
                        end else begin
                            r = push_char(r, ch);
                        end
                    end
                endcase
            end
        end
        return r;
    endfunction

    assign c        = s_tdata;
    assign fin      = s_tlast;
    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            hex_val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            hex_val = 4'(c - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
        code_take = code_reg;
        stop_take = stopped_reg;
        if (!stopped_reg) begin
            if (hex_ok) begin
                code_take = {code_reg[11:0], hex_val};
            end else begin
                stop_take = 1'b1;
            end
        end
    end

    // Next state of the decode mode.
    always_comb begin
        mode_next = mode_reg;
        if (push) begin
            unique case (mode_reg)
                MODE_NORMAL: begin
                    mode_next = (c == CHAR_BSLASH && !fin) ? MODE_ESCAPE : MODE_NORMAL;
                end
                MODE_ESCAPE: begin
                    mode_next = (c == CHAR_U && !fin) ? MODE_HEX : MODE_NORMAL;
                end
                MODE_HEX: begin
                    mode_next = (count_reg == 2'd3 || fin) ? MODE_NORMAL : MODE_HEX;
                end
                default: mode_next = MODE_NORMAL;
            endcase
        end
    end

    // Result bytes and hex collection state.
    always_comb begin
        push_entry   = '0;
        count_next   = count_reg;
        code_next    = code_reg;
        stopped_next = stopped_reg;
        held_we      = 1'b0;
        unique case (mode_reg)
            MODE_ESCAPE: begin
                if (c == CHAR_U) begin
                    if (fin) begin
                        push_entry = push_char(push_entry, CHAR_U);
                    end else begin
                        count_next   = 2'd0;
                        code_next    = '0;
                        stopped_next = 1'b0;
                    end
                end else begin
                    push_entry = push_char(push_entry, escape_map(c));
                end
            end
            MODE_HEX: begin
                if (count_reg == 2'd3) begin
                    push_entry = utf8_encode(code_take);
                    count_next = 2'd0;
                end else if (fin) begin
                    push_entry = replay_held(held_reg[0], held_reg[1], count_reg, c);
                end else begin
                    held_we      = 1'b1;
                    code_next    = code_take;
                    stopped_next = stop_take;
                    count_next   = count_reg + 2'd1;
                end
            end
            default: begin
                if (!(c == CHAR_BSLASH && !fin)) begin
                    push_entry = push_char(push_entry, c);
                end
            end
        endcase
        if (fin) begin
            count_next   = 2'd0;
            code_next    = '0;
            stopped_next = 1'b0;
        end
        push_entry.last = fin;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_NORMAL;
            count_reg   <= 2'd0;
            code_reg    <= '0;
            stopped_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            if (push) begin
                count_reg   <= count_next;
                code_reg    <= code_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push && held_we) begin
            held_reg[count_reg] <= c;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/jsu_back.sv
// Back part: a registered output stage sends queued bytes, one per cycle unless stalled.
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire jsu_entry_t  head,
    input  wire logic        empty,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
    output logic             m_tlast
);

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               valid_reg, valid_next;
    char_t              byte_reg;
    logic               run_reg;
    logic               end_reg;

    logic               load_ok;
    logic               emit;
    logic               drop;
    logic               final_byte;

    assign load_ok    = !valid_reg || m_tready;
    assign emit       = !empty && (head.count != '0) && load_ok;
    // Escape openers and the first three hex digits give empty entries, which are discarded.
    assign drop       = !empty && (head.count == '0);
    assign final_byte = (idx_reg == IDX_W'(head.count - 1'b1));
    assign pop        = drop || (emit && final_byte);

    always_comb begin
        idx_next = idx_reg;
        if (pop) begin
            idx_next = '0;
        end else if (emit) begin
            idx_next = idx_reg + 1'b1;
        end
        valid_next = valid_reg;
        if (emit) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            byte_reg <= head.data[idx_reg];
            run_reg  <= final_byte;
            end_reg  <= final_byte && head.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'b0000000, run_reg, byte_reg};
    assign m_tlast  = end_reg;

endmodule

`default_nettype wire

// File: hw/rtl/jsu_checker.sv
// Port-level checks of the string unescaper and their binding to the top level.
`default_nettype none

`include "json_string_unescape_utf8_assert.svh"

module jsu_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
    input  wire logic        m_tlast
);

    // The final byte of a string is always the last byte of its request.
    `JSU_ASSERT_NOW(a_end_is_run_last, m_tvalid && m_tlast, m_tdata[8], "string end without run end")

    // After reset the queue is not full (s_tready is high) and nothing is shown on the output.
    `JSU_ASSERT_NEXT(a_reset_idle, !aresetn, !m_tvalid && s_tready, "not idle after reset")

    // A stalled result holds its value.
    `JSU_ASSERT_NEXT(a_stall_hold, aresetn && m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // Unused data bits stay zero on every result.
    `JSU_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[15:9] == 7'b0000000, "padding bits set")

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (.*);

`default_nettype wire
